// ----- hdl/rwce_pkg.sv -----
`timescale 1ns / 1ps

package rwce_pkg;

   // Fixed field widths
   localparam int VERTEX_W   = 10;
   localparam int WORD_W     = 32;
   localparam int MOVES_W    = 32;
   localparam int KIND_W     = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 11;

   // Visited-store epoch tag width
   localparam int EPOCH_W = 8;

   // Operations
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // Graph kinds
   localparam logic [KIND_W-1:0] GRAPH_CLIQUE   = 2'd0;
   localparam logic [KIND_W-1:0] GRAPH_PATH     = 2'd1;
   localparam logic [KIND_W-1:0] GRAPH_LOLLIPOP = 2'd2;
   localparam logic [KIND_W-1:0] GRAPH_TREE     = 2'd3;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRAPH_KIND   = 1'd1;

   typedef struct packed {
      logic                operation;
      logic [VERTEX_W-1:0] start_vertex;
      logic [WORD_W-1:0]   random_word;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] current_vertex;
      logic [MOVES_W-1:0]  move_count;
      logic [VERTEX_W-1:0] unvisited_count;
      logic                covered;
      logic                bad_start;
   } rsp_type;

endpackage

// ----- hdl/random_walk_cover_engine.sv -----
`timescale 1ns / 1ps
// Random walk cover engine: walks a clique, path, lollipop or complete binary
// tree graph until every vertex has been visited.
// - req channel (valid/ready): one beat is a start (places the walker, clears
//   the visited marks, zeroes the move count) or a step (one random word picks
//   the next neighbor as (word * degree) >> 32).
// - rsp channel (valid/ready): exactly one beat per request beat, in order,
//   with position, move count, unvisited count, covered and bad_start.
// - csr channel (valid/ready, always ready): index 0 vertex count, index 1
//   graph kind. Write only while no request is in flight.
// Throughput is one beat per cycle while no clearing pass runs and rsp_ready is
// high: input register, one pass of degree / multiply / neighbor logic, then a
// stage that folds in the visited-store read, then the output register.
// The visited store is a RAM of epoch tags; a start just bumps the epoch.
// After reset, and on every 255th start, a clearing pass writes the whole RAM
// (MAX_VERTICES entries, at most 2047); req_ready stays low during that pass.
// When rsp_ready is low the pipe fills up (three beats) and then req_ready
// drops; nothing is lost or repeated.
module random_walk_cover_engine
   import rwce_pkg::*;
#(
   parameter int MAX_VERTICES = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Vertex count register is 11 bits, so n never exceeds 2047.
   localparam int NMAX = (MAX_VERTICES < 2047) ? MAX_VERTICES : 2047;
   localparam int VW   = $clog2(NMAX);       // vertex index width
   localparam int NW   = $clog2(NMAX + 1);   // vertex count width
   localparam int AW   = VW + 2;             // room for 2v+2
   localparam int CW   = (NW > VERTEX_W) ? NW : VERTEX_W;
   localparam int PW   = WORD_W + NW;        // pick product width
   // floor(x/3) = (x * 2731) >> 13 for x below 8192
   localparam int DIV3_MUL   = 2731;
   localparam int DIV3_SHIFT = 13;
   localparam int DW         = NW + 1 + DIV3_SHIFT;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

   typedef struct packed {
      logic [NW-1:0] rem_base;
      logic          dec_pend;   // step moved; decrement if target unvisited
      logic          bad;
   } s2_type;

   // ---------------- registers ----------------
   logic [NW-1:0]      n_ff, n_in;
   logic [NW-1:0]      c_ff, c_in;             // lollipop clique size
   logic [KIND_W-1:0]  kind_ff, kind_in;

   logic               in_valid_ff, in_valid_in;
   req_type            in_data_ff;

   logic [VW-1:0]      position_ff, position_in;
   logic [MOVES_W-1:0] moves_ff, moves_in;
   logic [NW-1:0]      remaining_ff, remaining_in;
   logic               active_ff, active_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               clearing_ff, clearing_in;
   logic [VW-1:0]      clr_idx_ff, clr_idx_in;

   logic               s2_valid_ff, s2_valid_in;
   s2_type             s2_ff, s2_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // ---------------- handshakes ----------------
   logic out_free, s2_move, s2_free, s1_fire, in_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_move   = s2_valid_ff && out_free;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_fire   = in_valid_ff && !clearing_ff && s2_free;
   assign in_free   = !in_valid_ff || s1_fire;
   assign req_ready = in_free && !clearing_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- config ----------------
   // n and floor(2n/3) are computed at write time so they land together.
   logic [NW-1:0] n_new;
   logic [DW-1:0] c_prod;

   assign n_new  = (csr_wdata > CSR_DATA_W'(NMAX)) ? NW'(NMAX) : NW'(csr_wdata);
   assign c_prod = DW'({n_new, 1'b0}) * DW'(DIV3_MUL);

   always_comb begin
      n_in    = n_ff;
      c_in    = c_ff;
      kind_in = kind_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_VERTEX_COUNT: begin
               n_in = n_new;
               c_in = NW'(c_prod >> DIV3_SHIFT);
            end
            CSR_GRAPH_KIND: kind_in = csr_wdata[KIND_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- stage 1: neighbor pick ----------------
   logic               op_start, sv_bad, start_ok, step_go, moved, v_pos;
   logic [NW-1:0]      rem_view, rem_out;
   logic [AW-1:0]      va, na, ca, ka, deg_a, nxt_a;
   logic [NW-1:0]      deg, pick_k;
   logic [PW-1:0]      pick_prod;
   logic [VW-1:0]      nxt, sv_idx;
   logic [EPOCH_W-1:0] epoch_next, rd_mark;
   logic               hit;

   assign op_start = in_data_ff.operation == OP_START;
   assign sv_bad   = CW'(in_data_ff.start_vertex) >= CW'(n_ff);
   assign start_ok = op_start && !sv_bad;
   assign sv_idx   = VW'(in_data_ff.start_vertex);
   assign step_go  = !op_start && active_ff && (rem_view != '0);

   assign va    = AW'(position_ff);
   assign na    = AW'(n_ff);
   assign ca    = AW'(c_ff);
   assign v_pos = position_ff != '0;

   always_comb begin
      deg_a = '0;
      if (va < na) begin
         case (kind_ff)
            GRAPH_CLIQUE: deg_a = na - AW'(1);
            GRAPH_PATH:   deg_a = AW'(v_pos) + AW'(va + AW'(1) < na);
            GRAPH_LOLLIPOP: begin
               if (va + AW'(1) < ca) begin
                  deg_a = ca - AW'(1);
               end else if (va + AW'(1) == ca) begin
                  deg_a = ca;   // last clique vertex also reaches the tail
               end else begin
                  deg_a = AW'(v_pos) + AW'(va + AW'(1) < na);
               end
            end
            GRAPH_TREE: deg_a = AW'(v_pos) + AW'((va << 1) + AW'(1) < na)
                              + AW'((va << 1) + AW'(2) < na);
            default: deg_a = '0;
         endcase
      end
   end

   assign deg       = NW'(deg_a);
   assign pick_prod = PW'(in_data_ff.random_word) * PW'(deg);
   assign pick_k    = pick_prod[PW-1:WORD_W];
   assign ka        = AW'(pick_k);

   always_comb begin
      nxt_a = va;
      case (kind_ff)
         GRAPH_CLIQUE: nxt_a = (ka < va) ? ka : ka + AW'(1);
         GRAPH_PATH:   nxt_a = (v_pos && ka == '0) ? va - AW'(1) : va + AW'(1);
         GRAPH_LOLLIPOP: begin
            if (va < ca) begin
               nxt_a = (ka < va) ? ka : ka + AW'(1);
            end else begin
               nxt_a = (v_pos && ka == '0) ? va - AW'(1) : va + AW'(1);
            end
         end
         GRAPH_TREE: begin
            if (v_pos && ka == '0) begin
               nxt_a = (va - AW'(1)) >> 1;   // parent
            end else begin
               nxt_a = (va << 1) + AW'(1) + ka - AW'(v_pos);
            end
         end
         default: nxt_a = va;
      endcase
   end

   assign nxt   = VW'(nxt_a);
   assign moved = step_go && (deg != '0);

   assign epoch_next = (epoch_ff == EPOCH_LAST) ? EPOCH_W'(1) : epoch_ff + EPOCH_W'(1);

   // ---------------- visited store ----------------
   logic               ram_wr_en;
   logic [VW-1:0]      ram_wr_addr;
   logic [EPOCH_W-1:0] ram_wr_data;

   always_comb begin
      if (clearing_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_idx_ff;
         // keep the running walk's start vertex marked across a wrap clear
         ram_wr_data = (active_ff && clr_idx_ff == position_ff) ? epoch_ff : '0;
      end else begin
         ram_wr_en   = s1_fire && (start_ok || moved);
         ram_wr_addr = start_ok ? sv_idx : nxt;
         ram_wr_data = start_ok ? epoch_next : epoch_ff;
      end
   end

   rwce_ram #(
      .WIDTH (EPOCH_W),
      .DEPTH (NMAX)
   ) u_visited (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (s1_fire),
      .rd_addr (nxt),
      .rd_data (rd_mark)
   );

   // ---------------- stage 2: fold in visited read ----------------
   assign hit      = rd_mark == epoch_ff;
   assign rem_out  = s2_ff.rem_base - NW'(s2_ff.dec_pend && !hit);
   assign rem_view = s2_valid_ff ? rem_out : remaining_ff;

   always_comb begin
      in_valid_in  = req_ready ? req_valid : (in_valid_ff && !s1_fire);

      position_in  = position_ff;
      moves_in     = moves_ff;
      active_in    = active_ff;
      epoch_in     = epoch_ff;
      clearing_in  = clearing_ff;
      clr_idx_in   = clr_idx_ff;

      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + VW'(1);
         if (clr_idx_ff == VW'(NMAX - 1)) begin
            clearing_in = 1'b0;
         end
      end

      if (s1_fire) begin
         if (start_ok) begin
            position_in = sv_idx;
            moves_in    = '0;
            active_in   = 1'b1;
            epoch_in    = epoch_next;
            if (epoch_ff == EPOCH_LAST) begin
               clearing_in = 1'b1;
               clr_idx_in  = '0;
            end
         end else if (step_go) begin
            if (moved) begin
               position_in = nxt;
            end
            if (moves_ff != '1) begin
               moves_in = moves_ff + MOVES_W'(1);
            end
         end
      end

      s2_in.rem_base = start_ok ? n_ff - NW'(1) : rem_view;
      s2_in.dec_pend = moved;
      s2_in.bad      = op_start && sv_bad;
      s2_valid_in    = s1_fire ? 1'b1 : (s2_valid_ff && !s2_move);

      remaining_in   = s2_move ? rem_out : remaining_ff;

      rsp_data_in.current_vertex  = VERTEX_W'(position_ff);
      rsp_data_in.move_count      = moves_ff;
      rsp_data_in.unvisited_count = VERTEX_W'(rem_out);
      rsp_data_in.covered         = active_ff && (rem_out == '0);
      rsp_data_in.bad_start       = s2_ff.bad;
      rsp_valid_in = s2_move ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   // ---------------- control state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= NW'(2);
         c_ff         <= NW'(1);
         kind_ff      <= GRAPH_CLIQUE;
         in_valid_ff  <= 1'b0;
         position_ff  <= '0;
         moves_ff     <= '0;
         remaining_ff <= '0;
         active_ff    <= 1'b0;
         epoch_ff     <= EPOCH_W'(1);
         clearing_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         n_ff         <= n_in;
         c_ff         <= c_in;
         kind_ff      <= kind_in;
         in_valid_ff  <= in_valid_in;
         position_ff  <= position_in;
         moves_ff     <= moves_in;
         remaining_ff <= remaining_in;
         active_ff    <= active_in;
         epoch_ff     <= epoch_in;
         clearing_ff  <= clearing_in;
         clr_idx_ff   <= clr_idx_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- payload ----------------
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (s1_fire) begin
         s2_ff <= s2_in;
      end
      if (s2_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------- checks ----------------
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_ready)
      else $error("request accepted during visited-store clear");

   a_no_rem_underflow: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_ff.dec_pend) |-> (s2_ff.rem_base != '0))
      else $error("pending decrement on zero unvisited count");

   a_bad_start_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && op_start && sv_bad) |=> ($stable(position_ff) && $stable(active_ff)))
      else $error("bad start changed walk state");

   a_moves_monotonic: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !op_start) |=> (moves_ff >= $past(moves_ff)))
      else $error("move count went down on a step");

endmodule

// ----- hdl/rwce_ram.sv -----
`timescale 1ns / 1ps

module rwce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents on a same-address write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
